// ===== rtl/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared sizes and constants for the reorder window: slot geometry, field
// widths, chunk mask and sequencer state codes.
// ----------------------------------------------------------------------------
package srrw_pkg;

  // Both must stay powers of two: slot index is a plain bit slice of byte_seq.
  localparam int WINDOW_SLOTS = 8;
  localparam int SLOT_BYTES   = 8;

  localparam int SEQ_W   = 32;
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 4;
  localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SLOT_SH = $clog2(SLOT_BYTES);

  localparam logic [CNT_W-1:0]  SLOT_BYTES_C = CNT_W'(SLOT_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT_C  = SLOT_W'(WINDOW_SLOTS - 1);

  localparam logic [DATA_W-1:0] CHUNK_MASK =
    (SLOT_BYTES >= 8) ? {DATA_W{1'b1}}
                      : ((DATA_W'(1) << (8 * SLOT_BYTES)) - DATA_W'(1));

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [DATA_W-1:0] chunk_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RELEASE = 2'b10
  } seq_state_t;

endpackage

// ===== rtl/srrw_slot_ram.sv =====
// ----------------------------------------------------------------------------
// srrw_slot_ram
// Slot payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrw_slot_ram (
  input  logic              clk,
  input  logic              wr_en,
  input  srrw_pkg::slot_idx_t wr_addr,
  input  srrw_pkg::chunk_t  wr_data,
  input  logic              rd_en,
  input  srrw_pkg::slot_idx_t rd_addr,
  output srrw_pkg::chunk_t  rd_data
);
  import srrw_pkg::*;

  chunk_t mem [WINDOW_SLOTS];
  chunk_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/selective_repeat_reorder_window.sv =====
// Output: the first result of a releasing request passes the sequencer state,
// slot RAM read and output registers; then one per cycle while the result side
// does not stall. Input: a request releasing nothing causes no stall; one that
// releases slots stalls it until its last chunk is in the output register.
// Reset: valid bits, final-slot marker and final byte count are cleared; slot
// payload RAM is not initialised.
// ----------------------------------------------------------------------------
// selective_repeat_reorder_window
// Receive reorder window: stores packets by slot, releases in-order runs.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srrw_pkg::SEQ_W-1:0]    in_byte_seq,
  input  logic [srrw_pkg::DATA_W-1:0]   in_payload,
  input  logic                          in_is_last,
  input  logic [srrw_pkg::CNT_W-1:0]    in_final_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srrw_pkg::DATA_W-1:0]   out_chunk_out,
  output logic [srrw_pkg::CNT_W-1:0]    out_byte_count,
  output logic                          out_run_end,
  output logic                          out_transfer_done
);
  import srrw_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [WINDOW_SLOTS-1:0] valid_r, valid_nxt;
  logic                    fin_seen_r, fin_seen_nxt;
  slot_idx_t               fin_slot_r, fin_slot_nxt;
  logic [CNT_W-1:0]        fin_bytes_r, fin_bytes_nxt;

  slot_idx_t idx_r, idx_nxt;
  slot_idx_t last_r, last_nxt;
  logic      done_r, done_nxt;

  logic             rd_vld_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_end_r;
  logic             rd_done_r;
  chunk_t           rd_data;

  logic             out_valid_r;
  chunk_t           out_chunk_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_end_r;
  logic             out_done_r;

  logic                    accept;
  slot_idx_t               in_slot;
  logic [WINDOW_SLOTS-1:0] valid_upd;
  logic                    prefix_ok;
  logic                    release_go;
  slot_idx_t               rel_last;
  logic                    issue;
  logic                    load;

  assign in_stall = (state_r != ST_IDLE) || rd_vld_r;
  assign accept   = in_valid && !in_stall;
  assign in_slot  = in_byte_seq[SLOT_SH +: SLOT_W];

  assign load  = rd_vld_r && (!out_valid_r || !out_stall);
  assign issue = (state_r == ST_RELEASE) && (!rd_vld_r || load);

  // Window update and release decision for the request being accepted
  always_comb begin
    fin_seen_nxt  = fin_seen_r;
    fin_slot_nxt  = fin_slot_r;
    fin_bytes_nxt = fin_bytes_r;
    if (accept && in_is_last) begin
      fin_seen_nxt  = 1'b1;
      fin_slot_nxt  = in_slot;
      fin_bytes_nxt = (in_final_count > SLOT_BYTES_C) ? SLOT_BYTES_C : in_final_count;
    end

    valid_upd = valid_r;
    valid_upd[in_slot] = 1'b1;

    prefix_ok = 1'b1;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (SLOT_W'(i) < fin_slot_nxt) begin
        prefix_ok = prefix_ok & valid_upd[i];
      end
    end

    release_go = fin_seen_nxt ? prefix_ok : (&valid_upd);
    rel_last   = fin_seen_nxt ? fin_slot_nxt : LAST_SLOT_C;

    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = valid_upd;
      if (release_go) begin
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
          if (SLOT_W'(i) <= rel_last) begin
            valid_nxt[i] = 1'b0;
          end
        end
      end
    end
  end

  // Release sequencer: one slot RAM read per step
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && release_go) begin
          state_nxt = ST_RELEASE;
          idx_nxt   = '0;
          last_nxt  = rel_last;
          done_nxt  = fin_seen_nxt;
        end
      end
      ST_RELEASE: begin
        if (issue) begin
          idx_nxt = idx_r + SLOT_W'(1);
          if (idx_r == last_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      fin_seen_r  <= 1'b0;
      fin_slot_r  <= '0;
      fin_bytes_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fin_seen_r  <= fin_seen_nxt;
      fin_slot_r  <= fin_slot_nxt;
      fin_bytes_r <= fin_bytes_nxt;
      if (issue) begin
        rd_vld_r <= 1'b1;
      end else if (load) begin
        rd_vld_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
    if (issue) begin
      // final slot of a finished transfer goes out with the final byte count
      rd_cnt_r  <= (done_r && idx_r == last_r) ? fin_bytes_r : SLOT_BYTES_C;
      rd_end_r  <= (idx_r == last_r);
      rd_done_r <= done_r;
    end
    if (load) begin
      out_chunk_r <= rd_data;
      out_cnt_r   <= rd_cnt_r;
      out_end_r   <= rd_end_r;
      out_done_r  <= rd_done_r;
    end
  end

  srrw_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (in_slot),
    .wr_data (in_payload & CHUNK_MASK),
    .rd_en   (issue),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_chunk_out     = out_chunk_r;
  assign out_byte_count    = out_cnt_r;
  assign out_run_end       = out_end_r;
  assign out_transfer_done = out_done_r;

endmodule

// ===== test/tb_selective_repeat_reorder_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_reorder_window
// Self-checking bench for the receive reorder window. A table of directed
// packets covers full-window flushes, wrapped sequence numbers, overwrites
// and final-slot runs, including zero and oversized final counts and the
// final-slot marker that outlives a completed transfer. Shuffled transfers
// and stray packets follow under several idle and stall mixes, plus one long
// output hold-off. Chunks are checked against the table or the local model.
// ----------------------------------------------------------------------------
module tb_selective_repeat_reorder_window;
  import srrw_pkg::*;

  localparam int            N_ROWS         = 24;
  localparam int            PHASE_ITEMS    = 80;
  localparam int            HOLD_ITEMS     = 26;
  localparam int            RX_HOLD_CYCLES = 400;
  localparam int            SETTLE_CYCLES  = 30;
  localparam logic [31:0]   WIN_SPAN_MASK  = 32'(WINDOW_SLOTS * SLOT_BYTES - 1);

  typedef struct packed {
    logic [SEQ_W-1:0] byte_seq;
    chunk_t           payload;
    logic             is_last;
    logic [CNT_W-1:0] final_count;
  } packet_t;

  typedef struct packed {
    chunk_t           chunk;
    logic [CNT_W-1:0] bytes;
    logic             run_end;
    logic             done;
  } chunk_rel_t;

  // Rows marked by_hand carry their result here: at most one chunk, which
  // then always ends its run.
  typedef struct {
    logic [SEQ_W-1:0] byte_seq;
    chunk_t           payload;
    logic             is_last;
    logic [CNT_W-1:0] final_count;
    bit               by_hand;
    int               n_hand;
    chunk_t           chunk;
    logic [CNT_W-1:0] bytes;
    logic             done;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SEQ_W-1:0]  in_byte_seq = '0;
  logic [DATA_W-1:0] in_payload = '0;
  logic              in_is_last = 1'b0;
  logic [CNT_W-1:0]  in_final_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_chunk_out;
  logic [CNT_W-1:0]  out_byte_count;
  logic              out_run_end;
  logic              out_transfer_done;

  // local copy of the window
  chunk_t           win_data [WINDOW_SLOTS];
  logic             win_full [WINDOW_SLOTS];
  logic             tail_known;
  slot_idx_t        tail_slot;
  logic [CNT_W-1:0] tail_bytes;

  chunk_rel_t pending_chunks [$];
  chunk_rel_t want;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_flushes    = 0;
  int n_tail_runs  = 0;
  int n_mismatches = 0;

  row_t directed_rows [N_ROWS] = '{
    // empty window after reset: nothing can go
    '{32'd8,          64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFFF,  64'h0000_0000_0000_0000, 1'b0, 4'd15, 1, 0, '0, '0, 1'b0},
    '{32'd16,         64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'd27,         64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'd32,         64'h8000_0000_0000_0001, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'd47,         64'h0123_4567_89AB_CDEF, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'd48,         64'hFEDC_BA98_7654_3210, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    // slot 0 completes the window: full flush
    '{32'd0,          64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 4'd0,  0, 0, '0, '0, 1'b0},
    // second window filled backwards across the sequence wrap
    '{32'hFFFF_FFF8,  64'h7777_0000_0000_0007, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFF0,  64'h6666_0000_0000_0006, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFE8,  64'h5555_0000_0000_0005, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFE0,  64'h4444_0000_0000_0004, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFD8,  64'h3333_0000_0000_0003, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFDB,  64'h3333_FFFF_FFFF_0033, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFD0,  64'h2222_0000_0000_0002, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'hFFFF_FFC8,  64'h1111_0000_0000_0001, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'h0000_0040,  64'h0000_0000_0000_0000, 1'b0, 4'd0,  0, 0, '0, '0, 1'b0},
    // final packet in slot 0 with a zero count
    '{32'd0,          64'hC0FF_EE00_DEAD_BEEF, 1'b1, 4'd0,  1, 1,
      64'hC0FF_EE00_DEAD_BEEF, 4'd0, 1'b1},
    // oversized count, slot 0 missing
    '{32'd8,          64'h1111_2222_3333_4444, 1'b1, 4'd15, 1, 0, '0, '0, 1'b0},
    '{32'd0,          64'h5555_6666_7777_8888, 1'b0, 4'd0,  0, 0, '0, '0, 1'b0},
    // marker kept after completion: slot 1 goes out again with old data
    '{32'd16,         64'h9999_AAAA_BBBB_CCCC, 1'b0, 4'd0,  1, 0, '0, '0, 1'b0},
    '{32'd0,          64'hDDDD_EEEE_FFFF_0000, 1'b0, 4'd0,  0, 0, '0, '0, 1'b0},
    '{32'd56,         64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 4'd9,  1, 0, '0, '0, 1'b0},
    '{32'd0,          64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd8,  1, 1,
      64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1}
  };

  selective_repeat_reorder_window dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_seq       (in_byte_seq),
    .in_payload        (in_payload),
    .in_is_last        (in_is_last),
    .in_final_count    (in_final_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chunk_out     (out_chunk_out),
    .out_byte_count    (out_byte_count),
    .out_run_end       (out_run_end),
    .out_transfer_done (out_transfer_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Store the packet, then scan from slot 0 for a releasable run.
  function automatic int advance_window(input packet_t p, output chunk_rel_t outs [WINDOW_SLOTS]);
    slot_idx_t s;
    int        last_i;
    logic      done;
    s = slot_idx_t'((p.byte_seq / SLOT_BYTES) % WINDOW_SLOTS);
    win_full[s] = 1'b1;
    win_data[s] = p.payload & CHUNK_MASK;
    if (p.is_last) begin
      tail_known = 1'b1;
      tail_slot  = s;
      tail_bytes = (p.final_count > SLOT_BYTES_C) ? SLOT_BYTES_C : p.final_count;
    end
    last_i = WINDOW_SLOTS - 1;
    done   = 1'b0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (tail_known && i == int'(tail_slot)) begin
        last_i = i;
        done   = 1'b1;
        break;
      end
      if (!win_full[i]) begin
        last_i = -1;
        break;
      end
    end
    for (int i = 0; i <= last_i; i++) begin
      outs[i] = '{win_data[i], (done && i == last_i) ? tail_bytes : SLOT_BYTES_C,
                  i == last_i, done};
      win_full[i] = 1'b0;
    end
    if (last_i >= 0) begin
      if (done) n_tail_runs++;
      else n_flushes++;
    end
    return last_i + 1;
  endfunction

  task automatic push_request(input packet_t p, output int n, output chunk_rel_t outs [WINDOW_SLOTS]);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_seq    <= p.byte_seq;
    in_payload     <= p.payload;
    in_is_last     <= p.is_last;
    in_final_count <= p.final_count;
    do @(posedge clk); while (in_stall);
    n = advance_window(p, outs);
    n_requests++;
  endtask

  task automatic send_predicted(input packet_t p);
    chunk_rel_t outs [WINDOW_SLOTS];
    int         n;
    push_request(p, n, outs);
    for (int k = 0; k < n; k++) pending_chunks.push_back(outs[k]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
  endtask

  // Mostly shuffled transfers ending at a random final slot, with repeats and
  // stray packets mixed in.
  task automatic random_traffic(input int n_items);
    packet_t     p;
    int          order [WINDOW_SLOTS];
    int          f;
    int          j;
    int          t;
    int          left;
    logic [31:0] r32;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(99) < 20) begin
        p.byte_seq    = $urandom;
        p.payload     = {$urandom, $urandom};
        p.is_last     = ($urandom_range(3) == 0);
        p.final_count = 4'($urandom_range(15));
        send_predicted(p);
        left--;
      end else begin
        f = ($urandom_range(3) == 0) ? WINDOW_SLOTS - 1 : $urandom_range(WINDOW_SLOTS - 1);
        for (int k = 0; k <= f; k++) order[k] = k;
        for (int k = f; k > 0; k--) begin
          j        = $urandom_range(k);
          t        = order[k];
          order[k] = order[j];
          order[j] = t;
        end
        for (int k = 0; k <= f && left > 0; k++) begin
          r32           = $urandom;
          p.byte_seq    = (r32 & ~WIN_SPAN_MASK) | 32'(order[k] * SLOT_BYTES) |
                          32'(r32 % SLOT_BYTES);
          p.payload     = {$urandom, $urandom};
          p.is_last     = (order[k] == f);
          p.final_count = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(SLOT_BYTES, 1));
          send_predicted(p);
          left--;
          // retransmission of the same slot
          if ($urandom_range(9) == 0 && left > 0) begin
            p.is_last = 1'b0;
            p.payload = {$urandom, $urandom};
            send_predicted(p);
            left--;
          end
        end
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_chunks.size() == 0) begin
        n_mismatches++;
        $display("%0t: unexpected chunk: expected none, got %h count %0d end %b done %b",
                 $time, out_chunk_out, out_byte_count, out_run_end, out_transfer_done);
      end else begin
        want = pending_chunks.pop_front();
        if (out_chunk_out !== want.chunk) begin
          n_mismatches++;
          $display("%0t: chunk_out: expected %h, got %h", $time, want.chunk, out_chunk_out);
        end
        if (out_byte_count !== want.bytes) begin
          n_mismatches++;
          $display("%0t: byte_count: expected %0d, got %0d", $time, want.bytes,
                   out_byte_count);
        end
        if (out_run_end !== want.run_end) begin
          n_mismatches++;
          $display("%0t: run_end: expected %b, got %b", $time, want.run_end, out_run_end);
        end
        if (out_transfer_done !== want.done) begin
          n_mismatches++;
          $display("%0t: transfer_done: expected %b, got %b", $time, want.done,
                   out_transfer_done);
        end
      end
    end
  end

  initial begin
    packet_t    p;
    chunk_rel_t outs [WINDOW_SLOTS];
    int         n;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      win_data[i] = '0;
      win_full[i] = 1'b0;
    end
    tail_known = 1'b0;
    tail_slot  = '0;
    tail_bytes = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      p = '{directed_rows[i].byte_seq, directed_rows[i].payload,
            directed_rows[i].is_last, directed_rows[i].final_count};
      push_request(p, n, outs);
      if (directed_rows[i].by_hand) begin
        if (directed_rows[i].n_hand == 1)
          pending_chunks.push_back('{directed_rows[i].chunk, directed_rows[i].bytes, 1'b1,
                                     directed_rows[i].done});
      end else begin
        for (int k = 0; k < n; k++) pending_chunks.push_back(outs[k]);
      end
    end
    drain();

    // idle mixes: none, sender only, receiver only, both
    for (int mode = 0; mode < 4; mode++) begin
      tx_idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 35 : 0;
      rx_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 35 : 0;
      random_traffic(PHASE_ITEMS / 2);
      // sender waits mid-phase until all expected chunks are out
      drain();
      random_traffic(PHASE_ITEMS / 2);
      drain();
    end

    // long output hold-off while requests keep coming
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_asked++;
    random_traffic(HOLD_ITEMS);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d packets: directed flushes, wrapped sequences and final-slot cases,",
             n_requests);
    $display("then shuffled transfers under four idle mixes and a %0d-cycle hold; %0d chunks checked (%0d flushes, %0d final runs).",
             RX_HOLD_CYCLES, n_results, n_flushes, n_tail_runs);
    if (n_mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/srrw_pkg.sv
rtl/srrw_slot_ram.sv
rtl/selective_repeat_reorder_window.sv
test/tb_selective_repeat_reorder_window.sv
